// ===== hdl/cartesian_to_polar_degrees_assert.svh =====
// assertion macros for the cartesian to polar checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef CARTESIAN_TO_POLAR_DEGREES_ASSERT_SVH
`define CARTESIAN_TO_POLAR_DEGREES_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define C2PD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define C2PD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/c2pd_pkg.sv =====
// shared constants, arctangent table and pipeline types for cartesian to polar
// no dependencies
package c2pd_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int ITERATIONS = 16;
    localparam int GUARD_BITS = 16;

    // angle output and accumulator widths (accumulator in 2^-16 degree)
    localparam int ANG_W = 15;
    localparam int Z_W   = ANG_W + 10;
    // cordic datapath, room for gain and the diagonal case
    localparam int CW    = DATA_WIDTH + GUARD_BITS + 3;
    // square root radicand and partial remainder
    localparam int SQ_W  = 2 * DATA_WIDTH;
    localparam int R_W   = DATA_WIDTH + 2;
    // stage index, covers up to 32 stages
    localparam int IDX_W = 5;
    localparam int N_STG = (ITERATIONS > DATA_WIDTH) ? ITERATIONS : DATA_WIDTH;

    localparam logic signed [Z_W-1:0] DEG_90     = Z_W'(90 * 65536);
    localparam logic signed [Z_W-1:0] DEG_180    = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(512);
    localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(11520);
    localparam logic signed [ANG_W:0]   FULL_TURN = (ANG_W + 1)'(23040);

    // atan(2^-i) in degrees, scaled by 2^16, zero past the useful entries
    localparam logic signed [Z_W-1:0] ATAN_TAB [2**IDX_W] = '{
        Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945),
        Z_W'(234379),  Z_W'(117304),  Z_W'(58666),  Z_W'(29335),
        Z_W'(14668),   Z_W'(7334),    Z_W'(3667),   Z_W'(1833),
        Z_W'(917),     Z_W'(458),     Z_W'(229),    Z_W'(115),
        Z_W'(57),      Z_W'(29),      Z_W'(14),     Z_W'(7),
        Z_W'(4),       Z_W'(2),       Z_W'(1),      Z_W'(0),
        Z_W'(0),       Z_W'(0),       Z_W'(0),      Z_W'(0),
        Z_W'(0),       Z_W'(0),       Z_W'(0),      Z_W'(0)
    };

    typedef struct packed {
        logic origin;
        logic x_zero;
        logic y_zero;
        logic y_neg;
        logic x_pos;
    } t_meta;

    typedef struct packed {
        t_meta                  meta;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic signed [Z_W-1:0]  z;
        logic [SQ_W-1:0]        rad;
        logic [DATA_WIDTH-1:0]  root;
        logic [R_W-1:0]         rem;
    } t_stg;

endpackage

// ===== hdl/c2pd_ifs.sv =====
// valid/ready channel interfaces for points in and polar results out
// depends on c2pd_pkg
interface c2pd_in_if;
    import c2pd_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] x_coord;
    logic signed [DATA_WIDTH-1:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2pd_out_if;
    import c2pd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [DATA_WIDTH-1:0]   magnitude;
    logic signed [ANG_W-1:0] angle;
    logic                    origin_error;

    modport source (output valid, output magnitude, output angle, output origin_error,
                    input ready);
    modport sink   (input valid, input magnitude, input angle, input origin_error,
                    output ready);
endinterface

// ===== hdl/cartesian_to_polar_degrees.sv =====
// cartesian to polar converter: magnitude and atan2(-x, y) in 1/64 degree
// from input transaction to result valid: 2 front register stages, N_STG stages, 1 out register
// throughput one transaction per cycle, the whole pipeline advances when the output
// register is empty or taken; a one-entry input skid keeps input ready registered
// synchronous active-low reset clears every valid bit and the skid, no clearing pass
// depends on c2pd_pkg, c2pd_ifs, c2pd_prep, c2pd_stage, c2pd_post
module cartesian_to_polar_degrees (
    input  logic              i_clk,
    input  logic              i_rst_n,
    c2pd_in_if.sink           i_point,
    c2pd_out_if.source        o_polar
);
    import c2pd_pkg::*;

    // pipeline advance: output register free or its transaction taken this cycle
    logic                         w_adv;

    // input skid, filled only when a transaction arrives during a stall
    logic                         r_skid_valid;
    logic                         n_skid_valid;
    logic signed [DATA_WIDTH-1:0] r_skid_x;
    logic signed [DATA_WIDTH-1:0] r_skid_y;

    logic                         w_feed_valid;
    logic signed [DATA_WIDTH-1:0] w_feed_x;
    logic signed [DATA_WIDTH-1:0] w_feed_y;

    // stage chain, entry 0 is the front end output
    logic                         w_vld [N_STG+1];
    t_stg                         w_stg [N_STG+1];

    logic [DATA_WIDTH-1:0]        w_magnitude;
    logic signed [ANG_W-1:0]      w_angle;
    logic                         w_origin_error;

    // output register
    logic                         r_out_valid;
    logic [DATA_WIDTH-1:0]        r_magnitude;
    logic signed [ANG_W-1:0]      r_angle;
    logic                         r_origin_error;

    assign w_adv         = !r_out_valid || o_polar.ready;
    assign i_point.ready = !r_skid_valid;

    // a held skid entry always goes first, otherwise the port feeds straight in
    assign w_feed_valid = r_skid_valid || i_point.valid;
    assign w_feed_x     = r_skid_valid ? r_skid_x : i_point.x_coord;
    assign w_feed_y     = r_skid_valid ? r_skid_y : i_point.y_coord;

    always_comb begin
        n_skid_valid = r_skid_valid;
        if (w_adv) begin
            n_skid_valid = 1'b0;
        end else if (!r_skid_valid && i_point.valid) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else begin
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid_x <= i_point.x_coord;
            r_skid_y <= i_point.y_coord;
        end
    end

    // squares, absolute values and axis/origin flags
    c2pd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_feed_valid),
        .i_x     (w_feed_x),
        .i_y     (w_feed_y),
        .o_valid (w_vld[0]),
        .o_stg   (w_stg[0])
    );

    // unrolled cordic and square root, one rotation and one root bit per stage
    for (genvar k = 0; k < N_STG; k++) begin : g_stage
        c2pd_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_idx   (IDX_W'(k)),
            .i_valid (w_vld[k]),
            .i_stg   (w_stg[k]),
            .o_valid (w_vld[k+1]),
            .o_stg   (w_stg[k+1])
        );
    end

    // quadrant mapping, rounding and origin override
    c2pd_post u_post (
        .i_stg          (w_stg[N_STG]),
        .o_magnitude    (w_magnitude),
        .o_angle        (w_angle),
        .o_origin_error (w_origin_error)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_vld[N_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_magnitude    <= w_magnitude;
            r_angle        <= w_angle;
            r_origin_error <= w_origin_error;
        end
    end

    assign o_polar.valid        = r_out_valid;
    assign o_polar.magnitude    = r_magnitude;
    assign o_polar.angle        = r_angle;
    assign o_polar.origin_error = r_origin_error;

endmodule

// ===== hdl/c2pd_prep.sv =====
// front end: squares, absolute values, special case flags, cordic start values
// two register stages, depends on c2pd_pkg
module c2pd_prep (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic signed [c2pd_pkg::DATA_WIDTH-1:0] i_x,
    input  logic signed [c2pd_pkg::DATA_WIDTH-1:0] i_y,
    output logic                                   o_valid,
    output c2pd_pkg::t_stg                         o_stg
);
    import c2pd_pkg::*;

    logic signed [SQ_W-1:0]  w_xx;
    logic signed [SQ_W-1:0]  w_yy;
    logic [DATA_WIDTH-1:0]   w_xu;
    logic [DATA_WIDTH-1:0]   w_yu;
    logic [DATA_WIDTH-1:0]   w_a;
    logic [DATA_WIDTH-1:0]   w_b;
    t_meta                   w_meta;

    logic                    r_v1;
    logic [SQ_W-1:0]         r_xx;
    logic [SQ_W-1:0]         r_yy;
    logic [DATA_WIDTH-1:0]   r_a;
    logic [DATA_WIDTH-1:0]   r_b;
    t_meta                   r_meta;
    logic                    r_v2;
    t_stg                    r_stg;
    t_stg                    n_stg;

    assign w_xx = i_x * i_x;
    assign w_yy = i_y * i_y;
    assign w_xu = i_x;
    assign w_yu = i_y;
    // cordic works on |y| (real axis) and |x| (imaginary axis)
    assign w_a  = w_yu[DATA_WIDTH-1] ? -w_yu : w_yu;
    assign w_b  = w_xu[DATA_WIDTH-1] ? -w_xu : w_xu;

    always_comb begin
        w_meta.x_zero = (i_x == '0);
        w_meta.y_zero = (i_y == '0);
        w_meta.origin = w_meta.x_zero && w_meta.y_zero;
        w_meta.y_neg  = i_y[DATA_WIDTH-1];
        w_meta.x_pos  = !i_x[DATA_WIDTH-1] && !w_meta.x_zero;
    end

    always_comb begin
        n_stg      = '0;
        n_stg.meta = r_meta;
        n_stg.cx   = CW'({r_a, {GUARD_BITS{1'b0}}});
        n_stg.cy   = CW'({r_b, {GUARD_BITS{1'b0}}});
        n_stg.rad  = r_xx + r_yy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx   <= w_xx;
            r_yy   <= w_yy;
            r_a    <= w_a;
            r_b    <= w_b;
            r_meta <= w_meta;
            r_stg  <= n_stg;
        end
    end

    assign o_valid = r_v2;
    assign o_stg   = r_stg;

endmodule

// ===== hdl/c2pd_stage.sv =====
// one pipeline stage: a cordic micro-rotation and one square root digit
// depends on c2pd_pkg, stage index comes in as a tied constant
module c2pd_stage (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic [c2pd_pkg::IDX_W-1:0]       i_idx,
    input  logic                             i_valid,
    input  c2pd_pkg::t_stg                   i_stg,
    output logic                             o_valid,
    output c2pd_pkg::t_stg                   o_stg
);
    import c2pd_pkg::*;

    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic [R_W-1:0]       w_part;
    logic [R_W-1:0]       w_trial;
    logic                 r_valid;
    t_stg                 r_stg;
    t_stg                 n_stg;

    assign w_dx    = i_stg.cy >>> i_idx;
    assign w_dy    = i_stg.cx >>> i_idx;
    // bring down the next two radicand bits, trial is 4q+1
    assign w_part  = {i_stg.rem[R_W-3:0], i_stg.rad[SQ_W-1 -: 2]};
    assign w_trial = {i_stg.root, 2'b01};

    always_comb begin
        n_stg = i_stg;
        if (int'(i_idx) < ITERATIONS) begin
            if (i_stg.cy > 0) begin
                n_stg.cx = i_stg.cx + w_dx;
                n_stg.cy = i_stg.cy - w_dy;
                n_stg.z  = i_stg.z + ATAN_TAB[i_idx];
            end else begin
                n_stg.cx = i_stg.cx - w_dx;
                n_stg.cy = i_stg.cy + w_dy;
                n_stg.z  = i_stg.z - ATAN_TAB[i_idx];
            end
        end
        if (int'(i_idx) < DATA_WIDTH) begin
            n_stg.rad = i_stg.rad << 2;
            if (w_part >= w_trial) begin
                n_stg.rem  = w_part - w_trial;
                n_stg.root = {i_stg.root[DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_stg.rem  = w_part;
                n_stg.root = {i_stg.root[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stg <= n_stg;
        end
    end

    assign o_valid = r_valid;
    assign o_stg   = r_stg;

endmodule

// ===== hdl/c2pd_post.sv =====
// back end: clamp, quadrant mapping, rounding to 1/64 degree, magnitude rounding
// combinational, depends on c2pd_pkg
module c2pd_post (
    input  c2pd_pkg::t_stg                   i_stg,
    output logic [c2pd_pkg::DATA_WIDTH-1:0]  o_magnitude,
    output logic signed [c2pd_pkg::ANG_W-1:0] o_angle,
    output logic                             o_origin_error
);
    import c2pd_pkg::*;

    logic signed [Z_W-1:0]   w_clamp;
    logic signed [Z_W-1:0]   w_phi;
    logic signed [Z_W-1:0]   w_ang;
    logic signed [Z_W-1:0]   w_sum;
    logic signed [ANG_W-1:0] w_r;
    logic signed [ANG_W:0]   w_wrap;
    logic [DATA_WIDTH-1:0]   w_mag;

    always_comb begin
        priority if (i_stg.z < 0) begin
            w_clamp = '0;
        end else if (i_stg.z > DEG_90) begin
            w_clamp = DEG_90;
        end else begin
            w_clamp = i_stg.z;
        end
    end

    // points on an axis are exact
    always_comb begin
        priority if (i_stg.meta.x_zero) begin
            w_phi = '0;
        end else if (i_stg.meta.y_zero) begin
            w_phi = DEG_90;
        end else begin
            w_phi = w_clamp;
        end
    end

    always_comb begin
        unique case ({i_stg.meta.y_neg, i_stg.meta.x_pos})
            2'b00:   w_ang = w_phi;
            2'b01:   w_ang = -w_phi;
            2'b10:   w_ang = DEG_180 - w_phi;
            default: w_ang = w_phi - DEG_180;
        endcase
    end

    assign w_sum  = w_ang + ROUND_HALF;
    assign w_r    = w_sum[Z_W-1:10];
    assign w_wrap = {w_r[ANG_W-1], w_r} - FULL_TURN;
    // round(sqrt) from floor root: bump when remainder exceeds root
    assign w_mag  = i_stg.root + DATA_WIDTH'(i_stg.rem > R_W'(i_stg.root));

    always_comb begin
        if (i_stg.meta.origin) begin
            o_magnitude    = '0;
            o_angle        = '0;
            o_origin_error = 1'b1;
        end else begin
            o_magnitude    = w_mag;
            o_angle        = (w_r >= HALF_TURN) ? w_wrap[ANG_W-1:0] : w_r;
            o_origin_error = 1'b0;
        end
    end

endmodule

// ===== hdl/c2pd_checker.sv =====
// port-level checker for the cartesian to polar converter, bound to the top level
// depends on c2pd_pkg and cartesian_to_polar_degrees_assert.svh
`include "cartesian_to_polar_degrees_assert.svh"

module c2pd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [c2pd_pkg::DATA_WIDTH-1:0]    i_magnitude,
    input logic signed [c2pd_pkg::ANG_W-1:0]  i_angle,
    input logic                               i_origin_error
);
    import c2pd_pkg::*;

    `C2PD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `C2PD_ASSERT_NOW(a_origin_zero, i_out_valid && i_origin_error, i_magnitude == '0 && i_angle == '0, "origin result not zero")
    `C2PD_ASSERT_NOW(a_mag_nonzero, i_out_valid && !i_origin_error, i_magnitude != '0, "zero magnitude off origin")
    `C2PD_ASSERT_NOW(a_angle_range, i_out_valid, i_angle >= -HALF_TURN && i_angle < HALF_TURN, "angle out of range")
    `C2PD_ASSERT_NOW(a_skid_cause, !i_in_ready, $past(i_out_valid && !i_out_ready), "input blocked without output stall")

endmodule

bind cartesian_to_polar_degrees c2pd_checker u_c2pd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_point.ready),
    .i_out_valid    (o_polar.valid),
    .i_out_ready    (o_polar.ready),
    .i_magnitude    (o_polar.magnitude),
    .i_angle        (o_polar.angle),
    .i_origin_error (o_polar.origin_error)
);
